FILE: sv/mtcs_pkg.sv
package mtcs_pkg;

	localparam int COIL_COUNT     = 8;
	localparam int STORE_DEPTH    = 13 + (COIL_COUNT + 7) / 8;
	localparam int OVERFLOW_LIMIT = 4096;
	localparam int CNT_W          = 13;
	localparam int STORE_AW       = $clog2(STORE_DEPTH);
	localparam int COIL_AW        = $clog2(COIL_COUNT);
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0]  FC_READ_COILS = 8'h01;
	localparam logic [7:0]  FC_WRITE_ONE  = 8'h05;
	localparam logic [7:0]  FC_WRITE_MANY = 8'h0F;
	localparam logic [7:0]  EXC_FLAG      = 8'h80;
	localparam logic [15:0] COIL_ON_VAL   = 16'hFF00;

	localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'd1;
	localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'd2;
	localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;

	localparam logic [7:0] REG_SERVER_ID = 8'd0;
	localparam logic [7:0] REG_COIL_BASE = 8'd1;

	// reply job handed from the parser to the reply streamer
	typedef struct packed {
		logic        none;
		logic [15:0] tid;
		logic [7:0]  unit;
		logic [7:0]  fc;
		logic [7:0]  len;
		logic [7:0]  p8;
		logic [7:0]  p9;
		logic [15:0] w2;
		logic [3:0]  last_idx;
		logic [7:0]  coils;
	} job_t;

	function automatic logic addr_ok(input logic [15:0] a, input logic [15:0] base);
		logic [16:0] lo;
		logic [16:0] hi;
		lo = {1'b0, base};
		hi = lo + 17'(COIL_COUNT);
		return ({1'b0, a} >= lo) && ({1'b0, a} < hi);
	endfunction

endpackage

FILE: sv/modbus_tcp_coil_server_core.sv
// Modbus/TCP coil server for one client connection. Each input transfer is either a request
// byte or a local coil write; the parser keeps up with one byte per cycle as long as its
// two-entry job queue has room. Each input yields one output transfer when there is no reply,
// otherwise one per reply byte (9 for an exception, 10 for read coils, 12 for a write echo),
// streamed at one byte per cycle while out_ready is high, so sustained throughput is set by
// the reply streamer. Coil updates take effect when the frame's last byte is taken, and
// coil_states on every output transfer shows the coils after the input that caused it.
module modbus_tcp_coil_server_core import mtcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  coil_index,
	input  logic        coil_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        has_byte,
	output logic        last,
	output logic [7:0]  coil_states,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	job_t new_job;
	job_t head_job;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign in_ready  = !full;
	assign push      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	mtcs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push),
		.mode(mode), .rx_byte(rx_byte), .coil_index(coil_index), .coil_value(coil_value),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.job(new_job)
	);

	mtcs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_job(new_job),
		.pop(pop), .rd_job(head_job), .full(full), .empty(empty)
	);

	mtcs_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head_job), .head_valid(!empty), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .tx_byte(tx_byte),
		.has_byte(has_byte), .last(last), .coil_states(coil_states)
	);

endmodule

FILE: sv/mtcs_front.sv
module mtcs_front import mtcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  coil_index,
	input  logic        coil_value,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output job_t        job
);

	logic [7:0]             store_q [STORE_DEPTH];
	logic [CNT_W-1:0]       cnt_q;
	logic [COIL_COUNT-1:0]  coils_q;
	logic [7:0]             server_id_q;
	logic [15:0]            coil_base_q;

	logic [7:0]             nb [STORE_DEPTH];
	logic [CNT_W-1:0]       cnt_n;
	logic [CNT_W-1:0]       cnt_next;
	logic [15:0]            len_f;
	logic                   serve;
	logic [COIL_COUNT-1:0]  coils_n;
	logic [15:0]            start;
	logic [15:0]            w10;
	logic [15:0]            end_a;
	logic [15:0]            off;
	logic [15:0]            qty_bytes;
	logic [8:0]             qmask;
	logic [COIL_COUNT-1:0]  rd_bits;
	logic                   hdr_ok;
	logic [7:0]             fc;

	always_comb begin
		nb = store_q;
		if (!mode && cnt_q < CNT_W'(STORE_DEPTH)) begin
			nb[cnt_q[STORE_AW-1:0]] = rx_byte;
		end
	end

	assign cnt_n = cnt_q + 1'b1;
	assign len_f = {nb[4], nb[5]};
	assign serve = (cnt_n >= CNT_W'(7)) && (len_f >= 16'd2)
		&& ({4'd0, cnt_n} == {1'b0, len_f} + 17'd6);
	assign start  = {nb[8], nb[9]};
	assign w10    = {nb[10], nb[11]};
	assign end_a  = start + w10 - 16'd1;
	assign off    = start - coil_base_q;
	assign qty_bytes = (w10 + 16'd7) >> 3;
	assign qmask  = (9'd1 << w10[3:0]) - 9'd1;
	assign rd_bits = (coils_q >> off[COIL_AW-1:0]) & qmask[COIL_COUNT-1:0];
	assign hdr_ok = ({nb[2], nb[3]} == 16'd0) && (nb[6] == server_id_q);
	assign fc     = nb[7];

	always_comb begin
		coils_n      = coils_q;
		job          = '0;
		job.none     = 1'b1;
		job.tid      = {nb[0], nb[1]};
		job.unit     = nb[6];
		job.len      = 8'd3;
		job.fc       = fc | EXC_FLAG;
		if (mode) begin
			if (32'(coil_index) < COIL_COUNT) begin
				coils_n[coil_index[COIL_AW-1:0]] = coil_value;
			end
		end else if (serve && hdr_ok) begin
			job.none     = 1'b0;
			job.last_idx = 4'd8;
			job.p8       = EXC_ILLEGAL_FUNC;
			unique case (fc)
				FC_READ_COILS: begin
					if (cnt_n < CNT_W'(12) || w10 < 16'd1 || w10 > 16'(COIL_COUNT)) begin
						job.p8 = EXC_ILLEGAL_VALUE;
					end else if (!addr_ok(start, coil_base_q) || !addr_ok(end_a, coil_base_q)) begin
						job.p8 = EXC_ILLEGAL_ADDR;
					end else begin
						job.fc       = FC_READ_COILS;
						job.len      = 8'd4;
						job.p8       = 8'd1;
						job.p9       = 8'(rd_bits);
						job.last_idx = 4'd9;
					end
				end
				FC_WRITE_ONE: begin
					if (cnt_n < CNT_W'(12)) begin
						job.p8 = EXC_ILLEGAL_VALUE;
					end else if (!addr_ok(start, coil_base_q)) begin
						job.p8 = EXC_ILLEGAL_ADDR;
					end else if (w10 != COIL_ON_VAL && w10 != 16'd0) begin
						job.p8 = EXC_ILLEGAL_VALUE;
					end else begin
						coils_n[off[COIL_AW-1:0]] = (w10 == COIL_ON_VAL);
						job.fc       = FC_WRITE_ONE;
						job.len      = 8'd6;
						job.p8       = start[15:8];
						job.p9       = start[7:0];
						job.w2       = w10;
						job.last_idx = 4'd11;
					end
				end
				FC_WRITE_MANY: begin
					if (cnt_n < CNT_W'(13) || w10 < 16'd1 || w10 > 16'(COIL_COUNT)
						|| {8'd0, nb[12]} != qty_bytes
						|| {3'd0, cnt_n} < 16'd13 + {8'd0, nb[12]}) begin
						job.p8 = EXC_ILLEGAL_VALUE;
					end else if (!addr_ok(start, coil_base_q) || !addr_ok(end_a, coil_base_q)) begin
						job.p8 = EXC_ILLEGAL_ADDR;
					end else begin
						for (int i = 0; i < COIL_COUNT; i++) begin
							if (16'(i) < w10) begin
								coils_n[COIL_AW'(off[COIL_AW-1:0] + COIL_AW'(i))] = nb[13][i];
							end
						end
						job.fc       = FC_WRITE_MANY;
						job.len      = 8'd6;
						job.p8       = start[15:8];
						job.p9       = start[7:0];
						job.w2       = w10;
						job.last_idx = 4'd11;
					end
				end
				default: ;
			endcase
		end
		job.coils = 8'(coils_n);
	end

	always_comb begin
		cnt_next = cnt_q;
		if (!mode) begin
			if (serve || cnt_n > CNT_W'(OVERFLOW_LIMIT)) cnt_next = '0;
			else cnt_next = cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push) store_q <= nb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			coils_q     <= '0;
			server_id_q <= 8'd1;
			coil_base_q <= 16'd0;
		end else begin
			if (push) begin
				cnt_q   <= cnt_next;
				coils_q <= coils_n;
			end
			if (cfg_we && cfg_index == REG_SERVER_ID) server_id_q <= cfg_data[7:0];
			if (cfg_we && cfg_index == REG_COIL_BASE) coil_base_q <= cfg_data;
		end
	end

endmodule

FILE: sv/mtcs_queue.sv
module mtcs_queue import mtcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	job_t            mem [QUEUE_DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     count_q;

	assign full   = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(QUEUE_DEPTH)) else $error("job queue count out of range");

endmodule

FILE: sv/mtcs_back.sv
module mtcs_back import mtcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       has_byte,
	output logic       last,
	output logic [7:0] coil_states
);

	logic [3:0] idx_q;
	logic       load;
	logic       is_last;
	logic [7:0] byte_sel;

	assign load    = head_valid && (!out_valid || out_ready);
	assign is_last = head.none || (idx_q == head.last_idx);
	assign pop     = load && is_last;

	always_comb begin
		unique case (idx_q)
			4'd0:    byte_sel = head.tid[15:8];
			4'd1:    byte_sel = head.tid[7:0];
			4'd5:    byte_sel = head.len;
			4'd6:    byte_sel = head.unit;
			4'd7:    byte_sel = head.fc;
			4'd8:    byte_sel = head.p8;
			4'd9:    byte_sel = head.p9;
			4'd10:   byte_sel = head.w2[15:8];
			4'd11:   byte_sel = head.w2[7:0];
			default: byte_sel = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte     <= head.none ? 8'd0 : byte_sel;
			has_byte    <= !head.none;
			last        <= is_last;
			coil_states <= head.coils;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (pop) idx_q <= '0;
			else if (load) idx_q <= idx_q + 1'b1;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= 4'd11) else $error("reply byte index past end");
	a_none_single: assert property (@(posedge clk) disable iff (!arst_n)
		(load && head.none) |-> idx_q == 4'd0) else $error("empty reply mid stream");
	a_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 4'd0) else $error("byte index not cleared");

endmodule
